// ===== rtl/core/rmbs_pkg.sv =====
// rmbs_pkg: constants, widths and shared types of the rgb matrix bit-plane scanner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmbs_pkg;

    localparam int PANEL_WIDTH  = 32;
    localparam int PANEL_HEIGHT = 32;
    localparam int BIT_PLANES   = 8;

    localparam int PIXEL_COUNT = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int ROW_PAIRS   = PANEL_HEIGHT / 2;
    localparam int HALF_DEPTH  = PIXEL_COUNT / 2;

    localparam int COL_W     = $clog2(PANEL_WIDTH);
    localparam int ROW_W     = $clog2(ROW_PAIRS);
    localparam int PLANE_W   = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
    localparam int HALF_AW   = $clog2(HALF_DEPTH);

    // fixed field widths
    localparam int ADDR_W     = 10;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int BASE_W     = 16;
    localparam int CNT_W      = 23;
    localparam int ROW_SEL_W  = 4;
    localparam int BIT_IDX_W  = $clog2(COLOR_W);
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;

    localparam logic [BASE_W-1:0] BASE_ON_TIME_RESET = 16'd10;

    // s_tuser codes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // scan position of the tick being accepted
    typedef struct packed {
        logic               shifting;
        logic               latch;
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic [COL_W-1:0]   col;
    } scan_info_t;

    // panel pin word, lowest bit last
    typedef struct packed {
        logic [2:0]           pad;
        logic [ROW_SEL_W-1:0] row_select;
        logic                 display_enable;
        logic                 latch_strobe;
        logic                 shift_clock;
        logic                 blue_bottom;
        logic                 green_bottom;
        logic                 red_bottom;
        logic                 blue_top;
        logic                 green_top;
        logic                 red_top;
    } pins_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_matrix_bitplane_scanner_unit.sv =====
// Top level: two-half frame store with a 32x32 bit-plane panel scanner
// A tick word passes the stage 1 register and the output register before it appears on m_tdata.
// Throughput: one word per cycle when not stalled; shift ticks read both halves.
// Pixel writes land in the store at the accept edge and give no output word.
// Reset: counters and base_on_time (10) reset at once; s_tready stays low while
// both 512-entry halves of the store are swept to black.
// depends on rmbs_pkg, rmbs_frame_store, rmbs_scan_seq
`timescale 1ns / 1ps
`default_nettype none

module rgb_matrix_bitplane_scanner_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rmbs_pkg::S_DATA_W-1:0] s_tdata,  // pixel_address, pixel_color
    input  wire logic                          s_tuser,  // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // red_top, green_top, blue_top, red_bottom, green_bottom, blue_bottom,
    // shift_clock, latch_strobe, display_enable, row_select
    output logic      [rmbs_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rmbs_pkg::BASE_W-1:0]   cfg_data
);
    import rmbs_pkg::*;

    logic               accept, tick, wr;
    logic               out_load;
    logic               store_busy;
    scan_info_t         info;

    logic [ADDR_W-1:0]  in_addr;
    logic [COLOR_W-1:0] in_color;
    logic [COLOR_W-1:0] top_data, bot_data;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_shift_reg;
    logic               s1_latch_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [PLANE_W-1:0] s1_plane_reg;

    logic               out_valid_reg, out_valid_next;
    pins_t              out_reg, out_next;

    logic [BIT_IDX_W-1:0] r_idx, g_idx, b_idx;

    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_color = s_tdata[ADDR_W +: COLOR_W];

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !store_busy && (!s1_valid_reg || out_load);
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (s_tuser == MODE_TICK);
    assign wr       = accept && (s_tuser == MODE_WRITE);
    assign cfg_ready = 1'b1;

    rmbs_scan_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (tick),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .info     (info)
    );

    rmbs_frame_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr),
        .wr_addr  (in_addr),
        .wr_data  (in_color),
        .rd_en    (tick && info.shifting),
        .rd_row   (info.row),
        .rd_col   (info.col),
        .top_data (top_data),
        .bot_data (bot_data),
        .busy     (store_busy)
    );

    // stage 1: ram read in flight, tick attributes alongside
    always_comb
    begin
        if (tick)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_valid_reg && out_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            s1_shift_reg <= info.shifting;
            s1_latch_reg <= info.latch;
            s1_row_reg   <= info.row;
            s1_plane_reg <= info.plane;
        end
    end

    // output register: pick the plane bit of each channel
    always_comb
    begin
        r_idx = BIT_IDX_W'(s1_plane_reg);
        g_idx = BIT_IDX_W'(s1_plane_reg) + BIT_IDX_W'(CHAN_W);
        b_idx = BIT_IDX_W'(s1_plane_reg) + BIT_IDX_W'(2 * CHAN_W);

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next          = s1_valid_reg;
            out_next.pad            = '0;
            out_next.row_select     = ROW_SEL_W'(s1_row_reg);
            out_next.display_enable = !s1_shift_reg;
            out_next.latch_strobe   = s1_latch_reg;
            out_next.shift_clock    = s1_shift_reg;
            out_next.red_top        = s1_shift_reg && top_data[r_idx];
            out_next.green_top      = s1_shift_reg && top_data[g_idx];
            out_next.blue_top       = s1_shift_reg && top_data[b_idx];
            out_next.red_bottom     = s1_shift_reg && bot_data[r_idx];
            out_next.green_bottom   = s1_shift_reg && bot_data[g_idx];
            out_next.blue_bottom    = s1_shift_reg && bot_data[b_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rmbs_ram.sv =====
// rmbs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rmbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rmbs_frame_store.sv =====
// rmbs_frame_store: frame store split in upper and lower panel halves, with clear sweep
// depends on rmbs_pkg, rmbs_ram
`timescale 1ns / 1ps
`default_nettype none

module rmbs_frame_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [rmbs_pkg::ADDR_W-1:0]   wr_addr,
    input  wire logic [rmbs_pkg::COLOR_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [rmbs_pkg::ROW_W-1:0]    rd_row,
    input  wire logic [rmbs_pkg::COL_W-1:0]    rd_col,
    output logic      [rmbs_pkg::COLOR_W-1:0]  top_data,
    output logic      [rmbs_pkg::COLOR_W-1:0]  bot_data,
    output logic                               busy
);
    import rmbs_pkg::*;

    logic [HALF_AW-1:0] clr_addr_reg, clr_addr_next;
    logic               clr_busy_reg, clr_busy_next;

    logic               wr_in_range;
    logic               wr_bottom;
    logic [HALF_AW-1:0] wr_index;
    logic [HALF_AW-1:0] rd_index;

    logic               top_we, bot_we;
    logic [HALF_AW-1:0] ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;

    always_comb
    begin
        wr_in_range = 32'(wr_addr) < PIXEL_COUNT;
        wr_bottom   = 32'(wr_addr) >= HALF_DEPTH;
        wr_index    = wr_bottom ? HALF_AW'(32'(wr_addr) - HALF_DEPTH) : HALF_AW'(wr_addr);
        rd_index    = HALF_AW'(32'(rd_row) * PANEL_WIDTH + 32'(rd_col));
    end

    // after reset both halves are swept to black, one entry each per cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == HALF_DEPTH - 1)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            top_we    = 1'b1;
            bot_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            top_we    = wr_en && wr_in_range && !wr_bottom;
            bot_we    = wr_en && wr_in_range && wr_bottom;
            ram_waddr = wr_index;
            ram_wdata = wr_data;
        end
    end

    assign busy = clr_busy_reg;

    rmbs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (HALF_DEPTH)
    ) u_top_ram (
        .clk   (clk),
        .we    (top_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_index),
        .rdata (top_data)
    );

    rmbs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (HALF_DEPTH)
    ) u_bot_ram (
        .clk   (clk),
        .we    (bot_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_index),
        .rdata (bot_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rmbs_scan_seq.sv =====
// rmbs_scan_seq: scan position counters (column, plane, row pair) and on-time timer
// depends on rmbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmbs_scan_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        cfg_we,
    input  wire logic [rmbs_pkg::BASE_W-1:0] cfg_data,
    output rmbs_pkg::scan_info_t             info
);
    import rmbs_pkg::*;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               showing_reg, showing_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BASE_W-1:0]  base_reg, base_next;

    logic [CNT_W-1:0]   duration;
    logic [CNT_W-1:0]   cnt_inc;

    always_comb
    begin
        duration = CNT_W'(base_reg) << plane_reg;
        cnt_inc  = cnt_reg + 1'b1;

        row_next     = row_reg;
        plane_next   = plane_reg;
        col_next     = col_reg;
        showing_next = showing_reg;
        cnt_next     = cnt_reg;
        base_next    = cfg_we ? cfg_data : base_reg;

        if (step)
        begin
            if (!showing_reg)
            begin
                if (32'(col_reg) == PANEL_WIDTH - 1)
                begin
                    col_next     = '0;
                    showing_next = 1'b1;
                    cnt_next     = '0;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            else if (cnt_inc >= duration)
            begin
                showing_next = 1'b0;
                cnt_next     = '0;
                if (32'(plane_reg) == BIT_PLANES - 1)
                begin
                    plane_next = '0;
                    row_next   = (32'(row_reg) == ROW_PAIRS - 1) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                end
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            plane_reg   <= '0;
            col_reg     <= '0;
            showing_reg <= 1'b0;
            cnt_reg     <= '0;
            base_reg    <= BASE_ON_TIME_RESET;
        end
        else
        begin
            row_reg     <= row_next;
            plane_reg   <= plane_next;
            col_reg     <= col_next;
            showing_reg <= showing_next;
            cnt_reg     <= cnt_next;
            base_reg    <= base_next;
        end
    end

    always_comb
    begin
        info.shifting = !showing_reg;
        info.latch    = showing_reg && (cnt_reg == '0);
        info.row      = row_reg;
        info.plane    = plane_reg;
        info.col      = col_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rmbs_checker.sv =====
// rmbs_checker: port-level assertions on the scanner output words, bound to the top level
// depends on rmbs_pkg and rgb_matrix_bitplane_scanner_unit
`timescale 1ns / 1ps
`default_nettype none

module rmbs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rmbs_pkg::M_DATA_W-1:0] m_tdata
);

    // a word either shifts a column or lights the line, never both or neither
    a_shift_xor_display: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6] ^ m_tdata[8]))
        else $error("shift_clock and display_enable not exclusive");

    a_latch_in_display: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[7]) |-> m_tdata[8])
        else $error("latch_strobe outside display phase");

    a_dark_while_display: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[5:0] == 6'd0))
        else $error("colour bits set during display phase");

    // the first display word after a shift word carries the latch
    a_latch_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tdata[6]) ##1 (m_tvalid && m_tdata[8])
            |-> m_tdata[7] || $past(m_tdata[6], 1) == 1'b0)
        else $error("missing latch after shifting");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed while stalled");

endmodule

bind rgb_matrix_bitplane_scanner_unit rmbs_checker u_rmbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/rmbs_scan_checker.sv =====
// rmbs_scan_checker: watches the stream and config channels of the bit-plane scanner,
// predicts every panel pin word and compares it field by field with the block output
// depends on rmbs_pkg
`timescale 1ns / 1ps

module rmbs_scan_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [rmbs_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [rmbs_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [rmbs_pkg::BASE_W-1:0]   cfg_data,
    output int                                 error_count,
    output int                                 words_in_flight
);

    // shadow of the frame store and scan position
    logic [23:0] pixel_mem [0:1023];
    logic [3:0]  row_pos;
    logic [2:0]  plane_pos;
    logic [4:0]  col_pos;
    logic        lit_phase;
    logic [22:0] lit_count;
    logic [15:0] on_base;

    rmbs_pkg::pins_t pin_queue [$];

    task automatic note_mismatch(input string what, input int want, input int got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // one scan tick: pin levels for the current position, then step the position
    task automatic scan_tick(output rmbs_pkg::pins_t pins);
        logic [23:0] top_px;
        logic [23:0] bot_px;
        logic [31:0] lit_len;
        pins = '0;
        pins.row_select = row_pos;
        if (!lit_phase)
        begin
            top_px = pixel_mem[{1'b0, row_pos, col_pos}];
            bot_px = pixel_mem[{1'b1, row_pos, col_pos}];
            pins.red_top      = top_px[plane_pos];
            pins.green_top    = top_px[8 + plane_pos];
            pins.blue_top     = top_px[16 + plane_pos];
            pins.red_bottom   = bot_px[plane_pos];
            pins.green_bottom = bot_px[8 + plane_pos];
            pins.blue_bottom  = bot_px[16 + plane_pos];
            pins.shift_clock  = 1'b1;
            if (col_pos == 5'd31)
            begin
                col_pos   = '0;
                lit_phase = 1'b1;
                lit_count = '0;
            end
            else
            begin
                col_pos = col_pos + 5'd1;
            end
        end
        else
        begin
            lit_len = {16'd0, on_base} << plane_pos;
            pins.latch_strobe   = (lit_count == 23'd0);
            pins.display_enable = 1'b1;
            lit_count = lit_count + 23'd1;
            // a zero on-time still gives the latch tick
            if ({9'd0, lit_count} >= lit_len)
            begin
                lit_phase = 1'b0;
                lit_count = '0;
                if (plane_pos == 3'd7)
                    row_pos = row_pos + 4'd1;
                plane_pos = plane_pos + 3'd1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rmbs_pkg::pins_t got;
        rmbs_pkg::pins_t want;
        rmbs_pkg::pins_t tick_pins;
        if (!rst_n)
        begin
            for (int i = 0; i < 1024; i++)
                pixel_mem[i] = '0;
            row_pos   = '0;
            plane_pos = '0;
            col_pos   = '0;
            lit_phase = 1'b0;
            lit_count = '0;
            on_base   = rmbs_pkg::BASE_ON_TIME_RESET;
            pin_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                on_base = cfg_data;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pin_queue.size() == 0)
                begin
                    note_mismatch("unexpected word", -1, int'(m_tdata));
                end
                else
                begin
                    want = pin_queue.pop_front();
                    if (got.red_top != want.red_top)
                        note_mismatch("red_top", want.red_top, got.red_top);
                    if (got.green_top != want.green_top)
                        note_mismatch("green_top", want.green_top, got.green_top);
                    if (got.blue_top != want.blue_top)
                        note_mismatch("blue_top", want.blue_top, got.blue_top);
                    if (got.red_bottom != want.red_bottom)
                        note_mismatch("red_bottom", want.red_bottom, got.red_bottom);
                    if (got.green_bottom != want.green_bottom)
                        note_mismatch("green_bottom", want.green_bottom, got.green_bottom);
                    if (got.blue_bottom != want.blue_bottom)
                        note_mismatch("blue_bottom", want.blue_bottom, got.blue_bottom);
                    if (got.shift_clock != want.shift_clock)
                        note_mismatch("shift_clock", want.shift_clock, got.shift_clock);
                    if (got.latch_strobe != want.latch_strobe)
                        note_mismatch("latch_strobe", want.latch_strobe, got.latch_strobe);
                    if (got.display_enable != want.display_enable)
                        note_mismatch("display_enable", want.display_enable,
                                      got.display_enable);
                    if (got.row_select != want.row_select)
                        note_mismatch("row_select", want.row_select, got.row_select);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == rmbs_pkg::MODE_WRITE)
                begin
                    pixel_mem[s_tdata[9:0]] = s_tdata[33:10];
                end
                else
                begin
                    scan_tick(tick_pins);
                    pin_queue.push_back(tick_pins);
                end
            end
        end
        words_in_flight = pin_queue.size();
    end

endmodule

// ===== bench/rgb_matrix_bitplane_scanner_unit_test.sv =====
// rgb_matrix_bitplane_scanner_unit_test: drives pixel writes, scan ticks and on-time
// settings into the scanner with random idling; verdict from rmbs_scan_checker
// depends on rmbs_pkg, rgb_matrix_bitplane_scanner_unit, rmbs_scan_checker
`timescale 1ns / 1ps

module rgb_matrix_bitplane_scanner_unit_test;

    localparam int CYCLE_LIMIT = 400000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [rmbs_pkg::S_DATA_W-1:0] s_tdata;   // pixel_address, pixel_color
    logic                          s_tuser;   // mode
    logic                          m_tvalid;
    logic                          m_tready;
    // red_top, green_top, blue_top, red_bottom, green_bottom, blue_bottom,
    // shift_clock, latch_strobe, display_enable, row_select
    logic [rmbs_pkg::M_DATA_W-1:0] m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rmbs_pkg::BASE_W-1:0]   cfg_data;

    int   error_count;
    int   words_in_flight;
    int   cycle_count = 0;
    logic idle_enable = 1'b1;

    always #4 clk = ~clk;

    rgb_matrix_bitplane_scanner_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rmbs_scan_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .words_in_flight (words_in_flight)
    );

    // one input word, with an optional idle burst in front of it
    task automatic push_word(input logic mode, input logic [9:0] addr,
                             input logic [23:0] color);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, color, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // on-time is only changed once every tick word has come out
    task automatic write_on_time(input logic [15:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly ticks; writes favor the first row pairs so the scan shows them
    task automatic run_random(input int count);
        logic [9:0]  addr;
        logic [23:0] color;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    addr = 10'($urandom_range(0, 1023));
                else
                    addr = {1'($urandom_range(0, 1)), 4'($urandom_range(0, 2)),
                            5'($urandom_range(0, 31))};
                case ($urandom_range(0, 5))
                    0:       color = 24'h000000;
                    1:       color = 24'hFFFFFF;
                    default: color = 24'($urandom);
                endcase
                push_word(rmbs_pkg::MODE_WRITE, addr, color);
            end
            else
            begin
                push_word(rmbs_pkg::MODE_TICK, 10'($urandom), 24'($urandom));
            end
        end
    endtask

    // receiver side back-pressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = rmbs_pkg::MODE_TICK;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: color extremes, both halves, a write behind and ahead of the scan
        push_word(rmbs_pkg::MODE_WRITE, 10'd0,    24'hFFFFFF);
        push_word(rmbs_pkg::MODE_WRITE, 10'd1023, 24'hFFFFFF);
        push_word(rmbs_pkg::MODE_WRITE, 10'd512,  24'h010204);
        push_word(rmbs_pkg::MODE_WRITE, 10'd1,    24'h000000);
        push_word(rmbs_pkg::MODE_WRITE, 10'd2,    24'h00FF00);
        push_word(rmbs_pkg::MODE_TICK,  10'd0,    24'h000000);
        push_word(rmbs_pkg::MODE_TICK,  10'h3FF,  24'hFFFFFF);
        push_word(rmbs_pkg::MODE_WRITE, 10'd2,    24'hFF00FF);
        push_word(rmbs_pkg::MODE_TICK,  10'd0,    24'h000000);
        push_word(rmbs_pkg::MODE_WRITE, 10'd513,  24'hFFFFFF);
        push_word(rmbs_pkg::MODE_WRITE, 10'd515,  24'hFFFFFF);
        for (int i = 0; i < 14; i++)
            push_word(rmbs_pkg::MODE_TICK, 10'd0, 24'h000000);

        // random phases over several on-times, reset value first
        run_random(100);
        write_on_time(16'd1);
        run_random(100);

        // zero on-time: scattered writes, then a run of short planes
        write_on_time(16'd0);
        for (int i = 0; i < 64; i++)
            push_word(rmbs_pkg::MODE_WRITE, 10'($urandom), 24'($urandom));
        for (int i = 0; i < 180; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_word(rmbs_pkg::MODE_WRITE, 10'($urandom), 24'($urandom));
            else
                push_word(rmbs_pkg::MODE_TICK, 10'($urandom), 24'($urandom));
        end

        write_on_time(16'hFFFF);
        run_random(60);
        write_on_time(16'($urandom_range(1, 40)));
        run_random(60);

        // last part with no idling on either side
        write_on_time(16'd3);
        idle_enable = 1'b0;
        run_random(60);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0 && words_in_flight == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
